FILE: hdl/kmst_pkg.sv
// Shared constants, types and helpers for the Kruskal spanning tree engine.
package kmst_pkg;

  localparam int MAX_EDGES    = 256;
  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 32;

  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int CNT_W   = EDGE_AW + 1;
  localparam int VERT_AW = $clog2(MAX_VERTICES);
  localparam int VERT_W  = 7;
  localparam int NUM_W   = 9;

  // One sorted-list entry: edge number and its weight (the sort key).
  typedef struct packed {
    logic [CNT_W-1:0]       num;
    logic [WEIGHT_BITS-1:0] weight;
  } sent_t;

  // One stored edge.
  typedef struct packed {
    logic [VERT_W-1:0]      left;
    logic [VERT_W-1:0]      right;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  // Load request from the front end into the back end's memories.
  typedef struct packed {
    logic             we;
    logic [EDGE_AW-1:0] addr;
    logic [CNT_W-1:0] num;
    edge_t            data;
  } load_t;

  // One closed graph waiting for the back end.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             drop;
  } job_t;

  typedef enum logic [4:0] {
    B_IDLE, B_SD_RD_E, B_SD_LAT_E, B_SD_TEST, B_SD_RD_C1, B_SD_CMP, B_SD_DONE,
    B_SW_RD1, B_SW_RD2, B_SW_W1, B_SW_W2,
    B_SC_RD_S, B_SC_RD_E, B_SC_CHK, B_FU_RD, B_FU_CMP, B_FV_RD, B_FV_CMP,
    B_SC_LINK, B_SC_NEXT, B_END
  } back_state_t;

  // 1-based list position to memory address.
  function automatic logic [EDGE_AW-1:0] pos2a(input logic [CNT_W:0] pos);
    logic [CNT_W:0] t;
    t = pos - 1'b1;
    return t[EDGE_AW-1:0];
  endfunction

endpackage

FILE: hdl/kmst_front.sv
// Front end: accepts edges, numbers them, tracks capacity, closes graphs.
module kmst_front import kmst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VERT_W-1:0]      edge_left,
  input  logic [VERT_W-1:0]      edge_right,
  input  logic [WEIGHT_BITS-1:0] edge_weight,
  input  logic                   final_edge,
  input  logic                   job_done,
  output logic                   busy,
  output load_t                  load,
  output logic                   push,
  output job_t                   job
);

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             locked;
  logic             accept;
  logic             full;
  logic [CNT_W-1:0] cnt_inc;

  assign busy    = locked;
  assign accept  = start & ~locked;
  assign full    = (count == CNT_W'(MAX_EDGES));
  assign cnt_inc = count + 1'b1;

  // store request for an accepted edge that fits
  always_comb begin
    load.we          = accept & ~full;
    load.addr        = count[EDGE_AW-1:0];
    load.num         = cnt_inc;
    load.data.left   = edge_left;
    load.data.right  = edge_right;
    load.data.weight = edge_weight;
    push             = accept & final_edge;
    job.count        = full ? count : cnt_inc;
    job.drop         = overflow | full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      locked   <= 1'b0;
    end else begin
      if (accept) begin
        if (final_edge) begin
          count    <= '0;
          overflow <= 1'b0;
          locked   <= 1'b1;
        end else if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= cnt_inc;
        end
      end
      if (job_done) begin
        locked <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/kmst_queue.sv
// Two-entry job queue between the front end and the back end.
module kmst_queue import kmst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign empty = (fill == 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && fill != 2'd2) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && fill != 2'd2) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'((push && fill != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

FILE: hdl/kmst_back.sv
// Back end: heap sort of the edge list, then union-find scan and result output.
module kmst_back import kmst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  load_t                  load,
  input  logic                   job_avail,
  input  job_t                   job,
  output logic                   pop,
  output logic                   job_done,
  output logic                   result_valid,
  output logic [NUM_W-1:0]       tree_edge_number,
  output logic [VERT_W-1:0]      tree_left,
  output logic [VERT_W-1:0]      tree_right,
  output logic [WEIGHT_BITS-1:0] tree_weight,
  output logic                   tree_last,
  output logic                   tree_none,
  output logic                   edges_dropped
);

  back_state_t state, state_next;

  // memories
  sent_t smem [MAX_EDGES];
  edge_t emem [MAX_EDGES];
  logic [VERT_W-1:0] pmem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pvalid;

  logic               s_we;
  logic [EDGE_AW-1:0] s_waddr, s_raddr;
  sent_t              s_wdata, s_rdata;
  logic [EDGE_AW-1:0] e_raddr;
  edge_t              e_rdata;
  logic               p_we;
  logic [VERT_AW-1:0] p_raddr, p_waddr;
  logic [VERT_W-1:0]  p_rdata;

  // control and datapath registers
  logic [CNT_W-1:0] m, i, p, lim;
  logic [CNT_W:0]   c;
  logic             drop, has_b, in_sort;
  sent_t            e_ent, a_ent;
  logic [VERT_W-1:0] cur_u, cur_v, x, cu;
  logic             pend_v;
  sent_t            pend_s;
  logic [VERT_W-1:0] pend_u, pend_v_r;

  // derived values
  logic [CNT_W:0]   c2;
  logic             pick_b, sift_stop;
  sent_t            chosen;
  logic [CNT_W:0]   c_sel;
  logic [VERT_W-1:0] par, x_m1, cu_m1;
  logic             u_ok, v_ok;
  logic [CNT_W-1:0] half_m;

  assign c2        = {p, 1'b0};
  assign pick_b    = has_b && ($signed(s_rdata.weight) >= $signed(a_ent.weight));
  assign chosen    = pick_b ? s_rdata : a_ent;
  assign c_sel     = c + (CNT_W+1)'(pick_b);
  assign sift_stop = $signed(chosen.weight) <= $signed(e_ent.weight);
  assign x_m1      = x - 1'b1;
  assign cu_m1     = cu - 1'b1;
  assign par       = pvalid[x_m1[VERT_AW-1:0]] ? p_rdata : x;
  assign u_ok      = (e_rdata.left >= VERT_W'(1)) && (e_rdata.left <= VERT_W'(MAX_VERTICES));
  assign v_ok      = (e_rdata.right >= VERT_W'(1)) && (e_rdata.right <= VERT_W'(MAX_VERTICES));
  assign half_m    = job.count >> 1;

  // sorted list memory: back end owns it while active, front loads it when idle
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[s_raddr];
  end

  // edge store
  always_ff @(posedge clk) begin
    if (load.we) begin
      emem[load.addr] <= load.data;
    end
    e_rdata <= emem[e_raddr];
  end

  // parent memory
  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= x;
    end
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    job_done   = 1'b0;
    s_we       = 1'b0;
    s_waddr    = pos2a({1'b0, p});
    s_wdata    = e_ent;
    s_raddr    = pos2a({1'b0, p});
    e_raddr    = pos2a({1'b0, s_rdata.num});
    p_we       = 1'b0;
    p_waddr    = cu_m1[VERT_AW-1:0];
    p_raddr    = x_m1[VERT_AW-1:0];
    case (state)
      B_IDLE: begin
        s_we    = load.we;
        s_waddr = load.addr;
        s_wdata = '{num: load.num, weight: load.data.weight};
        if (job_avail) begin
          pop = 1'b1;
          state_next = (half_m == '0) ? B_SC_RD_S : B_SD_RD_E;
        end
      end
      B_SD_RD_E:  state_next = B_SD_LAT_E;
      B_SD_LAT_E: state_next = B_SD_TEST;
      B_SD_TEST: begin
        if (c2 > {1'b0, lim}) begin
          s_we = 1'b1;
          state_next = B_SD_DONE;
        end else begin
          s_raddr = pos2a(c2);
          state_next = B_SD_RD_C1;
        end
      end
      B_SD_RD_C1: begin
        s_raddr = pos2a(c + 1'b1);
        state_next = B_SD_CMP;
      end
      B_SD_CMP: begin
        s_we = 1'b1;
        if (sift_stop) begin
          state_next = B_SD_DONE;
        end else begin
          s_wdata = chosen;
          state_next = B_SD_TEST;
        end
      end
      B_SD_DONE: begin
        if (!in_sort) begin
          state_next = (i == CNT_W'(1)) ? B_SW_RD1 : B_SD_RD_E;
        end else begin
          state_next = (i == CNT_W'(2)) ? B_SC_RD_S : B_SW_RD1;
        end
      end
      B_SW_RD1: begin
        s_raddr = pos2a({1'b0, i});
        state_next = B_SW_RD2;
      end
      B_SW_RD2: begin
        s_raddr = pos2a((CNT_W+1)'(1));
        state_next = B_SW_W1;
      end
      B_SW_W1: begin
        s_we    = 1'b1;
        s_waddr = pos2a({1'b0, i});
        s_wdata = s_rdata;
        state_next = B_SW_W2;
      end
      B_SW_W2: begin
        s_we    = 1'b1;
        s_waddr = pos2a((CNT_W+1)'(1));
        s_wdata = a_ent;
        state_next = B_SD_RD_E;
      end
      B_SC_RD_S: begin
        s_raddr = pos2a({1'b0, i});
        state_next = B_SC_RD_E;
      end
      B_SC_RD_E: state_next = B_SC_CHK;
      B_SC_CHK:  state_next = (u_ok && v_ok) ? B_FU_RD : B_SC_NEXT;
      B_FU_RD:   state_next = B_FU_CMP;
      B_FU_CMP:  state_next = (par == x) ? B_FV_RD : B_FU_RD;
      B_FV_RD:   state_next = B_FV_CMP;
      B_FV_CMP: begin
        if (par != x) begin
          state_next = B_FV_RD;
        end else begin
          state_next = (x == cu) ? B_SC_NEXT : B_SC_LINK;
        end
      end
      B_SC_LINK: begin
        p_we = 1'b1;
        state_next = B_SC_NEXT;
      end
      B_SC_NEXT: state_next = (i == m) ? B_END : B_SC_RD_S;
      B_END: begin
        job_done = 1'b1;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        m    <= job.count;
        drop <= job.drop;
        if (half_m == '0) begin
          i <= CNT_W'(1);
        end else begin
          i <= half_m;
        end
        p       <= half_m;
        lim     <= job.count;
        in_sort <= 1'b0;
      end
      B_SD_LAT_E: e_ent <= s_rdata;
      B_SD_TEST:  c <= c2;
      B_SD_RD_C1: begin
        a_ent <= s_rdata;
        has_b <= (c + 1'b1) <= {1'b0, lim};
      end
      B_SD_CMP: begin
        if (!sift_stop) begin
          p <= c_sel[CNT_W-1:0];
        end
      end
      B_SD_DONE: begin
        if (!in_sort) begin
          if (i == CNT_W'(1)) begin
            i <= m;
          end else begin
            i   <= i - 1'b1;
            p   <= i - 1'b1;
            lim <= m;
          end
        end else if (i == CNT_W'(2)) begin
          i <= CNT_W'(1);
        end else begin
          i <= i - 1'b1;
        end
      end
      B_SW_RD2: a_ent <= s_rdata;
      B_SW_W2: begin
        p       <= CNT_W'(1);
        lim     <= i - 1'b1;
        in_sort <= 1'b1;
      end
      B_SC_RD_E: e_ent <= s_rdata;
      B_SC_CHK: begin
        cur_u <= e_rdata.left;
        cur_v <= e_rdata.right;
        x     <= e_rdata.left;
      end
      B_FU_CMP: begin
        if (par == x) begin
          cu <= x;
          x  <= cur_v;
        end else begin
          x <= par;
        end
      end
      B_FV_CMP: begin
        if (par != x) begin
          x <= par;
        end
      end
      B_SC_NEXT: i <= i + 1'b1;
      default: ;
    endcase
  end

  // set valid bits and the result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid       <= '0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == B_SC_LINK && pend_v) || (state == B_END);
      if (state == B_IDLE && job_avail) begin
        pvalid <= '0;
        pend_v <= 1'b0;
      end
      if (state == B_SC_LINK) begin
        pvalid[cu_m1[VERT_AW-1:0]] <= 1'b1;
        pend_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_SC_LINK) begin
      pend_s   <= e_ent;
      pend_u   <= cur_u;
      pend_v_r <= cur_v;
      tree_edge_number <= NUM_W'(pend_s.num);
      tree_left        <= pend_u;
      tree_right       <= pend_v_r;
      tree_weight      <= pend_s.weight;
      tree_last        <= 1'b0;
      tree_none        <= 1'b0;
      edges_dropped    <= drop;
    end else if (state == B_END) begin
      tree_last     <= 1'b1;
      edges_dropped <= drop;
      tree_none     <= ~pend_v;
      if (pend_v) begin
        tree_edge_number <= NUM_W'(pend_s.num);
        tree_left        <= pend_u;
        tree_right       <= pend_v_r;
        tree_weight      <= pend_s.weight;
      end else begin
        tree_edge_number <= '0;
        tree_left        <= '0;
        tree_right       <= '0;
        tree_weight      <= '0;
      end
    end
  end

endmodule

FILE: hdl/kruskal_min_spanning_tree.sv
// Top level of the Kruskal minimum spanning tree engine.
//
// Usage: present one edge per request on edge_left, edge_right, edge_weight
// and final_edge with start high; the request is taken at a clock edge where
// busy is low. Edges are numbered 1 upward. Loading takes one edge per cycle
// while busy is low. The request with final_edge set closes the graph: busy
// rises and stays high until the last result has been produced. The back end
// then heap-sorts the list (about 1.5*m sift-downs plus a swap per sort step,
// bound by the one read port of the sorted-list memory) and scans it with a
// union-find that skips an edge with an end out of range and follows parent
// hops for the rest. Results appear on the tree_* ports for exactly one cycle
// each with result_valid high, in ascending weight order; tree_last marks the
// last one. An empty tree gives one result with tree_none set. The receiver
// cannot stall. Reset clears counts, flags and vertex sets; the edge and
// sorted memories need no clearing since only written entries are ever read.
module kruskal_min_spanning_tree import kmst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VERT_W-1:0]      edge_left,
  input  logic [VERT_W-1:0]      edge_right,
  input  logic [WEIGHT_BITS-1:0] edge_weight,
  input  logic                   final_edge,
  output logic                   result_valid,
  output logic [NUM_W-1:0]       tree_edge_number,
  output logic [VERT_W-1:0]      tree_left,
  output logic [VERT_W-1:0]      tree_right,
  output logic [WEIGHT_BITS-1:0] tree_weight,
  output logic                   tree_last,
  output logic                   tree_none,
  output logic                   edges_dropped
);

  load_t load;
  logic  push, pop, empty, job_done;
  job_t  push_job, head;

  kmst_front u_front (
    .clk(clk), .rst(rst), .start(start),
    .edge_left(edge_left), .edge_right(edge_right),
    .edge_weight(edge_weight), .final_edge(final_edge),
    .job_done(job_done), .busy(busy), .load(load),
    .push(push), .job(push_job)
  );

  kmst_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job),
    .pop(pop), .empty(empty), .head(head)
  );

  kmst_back u_back (
    .clk(clk), .rst(rst), .load(load),
    .job_avail(~empty), .job(head), .pop(pop), .job_done(job_done),
    .result_valid(result_valid), .tree_edge_number(tree_edge_number),
    .tree_left(tree_left), .tree_right(tree_right),
    .tree_weight(tree_weight), .tree_last(tree_last),
    .tree_none(tree_none), .edges_dropped(edges_dropped)
  );

endmodule

FILE: tb/tb_kruskal_min_spanning_tree.sv
// Self-checking testbench for the Kruskal minimum spanning tree engine.
`timescale 1ns / 1ps

module tb_kruskal_min_spanning_tree;
  import kmst_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE = 200;

  typedef struct {
    logic [VERT_W-1:0]             left;
    logic [VERT_W-1:0]             right;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic                          fin;
  } edge_req_t;

  typedef struct {
    logic [NUM_W-1:0]       num;
    logic [VERT_W-1:0]      left;
    logic [VERT_W-1:0]      right;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last;
    logic                   none;
    logic                   drop;
  } tree_res_t;

  logic clk, rst, start, busy;
  logic [VERT_W-1:0] edge_left, edge_right;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic final_edge, result_valid;
  logic [NUM_W-1:0] tree_edge_number;
  logic [VERT_W-1:0] tree_left, tree_right;
  logic [WEIGHT_BITS-1:0] tree_weight;
  logic tree_last, tree_none, edges_dropped;

  kruskal_min_spanning_tree i_dut (.*);

  // Requests waiting to go out, and tree edges still to come.
  edge_req_t pending_edges[$];
  tree_res_t expected_tree[$];
  edge_req_t cur;
  int idle_pct = 0;
  int errors = 0, edges_sent = 0, graphs_done = 0, tree_seen = 0, cycles = 0;

  // Predictor state: edge list, sort order, vertex sets.
  logic [VERT_W-1:0]             m_left[0:MAX_EDGES];
  logic [VERT_W-1:0]             m_right[0:MAX_EDGES];
  logic signed [WEIGHT_BITS-1:0] m_weight[0:MAX_EDGES];
  int m_order[0:MAX_EDGES];
  int m_parent[0:MAX_VERTICES];
  int m_count = 0;
  bit m_overflow = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic sift_down(input int first, input int lim);
    int e, p, c;
    logic signed [WEIGHT_BITS-1:0] w;
    e = m_order[first];
    w = m_weight[e];
    p = first;
    forever begin
      c = 2 * p;
      if (c > lim) break;
      // equal weights go to the right child
      if (c + 1 <= lim && m_weight[m_order[c+1]] >= m_weight[m_order[c]]) c++;
      if (m_weight[m_order[c]] <= w) break;
      m_order[p] = m_order[c];
      p = c;
    end
    m_order[p] = e;
  endtask

  function automatic int set_root(input int v);
    for (int s = 0; s <= MAX_VERTICES && m_parent[v] != v; s++) v = m_parent[v];
    return v;
  endfunction

  // Store one accepted edge; on the closing edge build the expected tree.
  task automatic build_tree(input edge_req_t r);
    int m, e, u, v, cu, cv, t, n;
    tree_res_t res;
    if (m_count < MAX_EDGES) begin
      m_count++;
      m_left[m_count] = r.left;
      m_right[m_count] = r.right;
      m_weight[m_count] = r.weight;
      m_order[m_count] = m_count;
    end else begin
      m_overflow = 1;
    end
    if (!r.fin) return;
    m = m_count;
    for (int i = m / 2; i >= 1; i--) sift_down(i, m);
    for (int i = m; i >= 2; i--) begin
      t = m_order[i];
      m_order[i] = m_order[1];
      m_order[1] = t;
      sift_down(1, i - 1);
    end
    for (int i = 0; i <= MAX_VERTICES; i++) m_parent[i] = i;
    n = 0;
    for (int pos = 1; pos <= m; pos++) begin
      e = m_order[pos];
      u = m_left[e];
      v = m_right[e];
      if (u < 1 || u > MAX_VERTICES || v < 1 || v > MAX_VERTICES) continue;
      cu = set_root(u);
      cv = set_root(v);
      if (cu == cv) continue;
      m_parent[cu] = cv;
      res = '{num: NUM_W'(e), left: VERT_W'(u), right: VERT_W'(v), weight: m_weight[e],
              last: 0, none: 0, drop: m_overflow};
      expected_tree.push_back(res);
      n++;
    end
    if (n == 0) begin
      res = '{num: 0, left: 0, right: 0, weight: 0, last: 1, none: 1, drop: m_overflow};
      expected_tree.push_back(res);
    end else begin
      expected_tree[expected_tree.size()-1].last = 1;
    end
    m_count = 0;
    m_overflow = 0;
    graphs_done++;
  endtask

  // Driver: one request per handshake, random gaps per idle_pct.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        build_tree(cur);
        edges_sent++;
      end
      if (start && busy) begin
        // hold the request until taken
      end else if (pending_edges.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        cur = pending_edges.pop_front();
        start <= 1'b1;
        edge_left <= cur.left;
        edge_right <= cur.right;
        edge_weight <= cur.weight;
        final_edge <= cur.fin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: every strobed result against the oldest expected tree edge.
  always @(posedge clk) begin
    tree_res_t x;
    if (!rst && result_valid) begin
      tree_seen++;
      if (expected_tree.size() == 0) begin
        $display("%0t: unexpected result, actual edge %0d", $time, tree_edge_number);
        errors++;
      end else begin
        x = expected_tree.pop_front();
        check_field("tree_edge_number", x.num, tree_edge_number);
        check_field("tree_left", x.left, tree_left);
        check_field("tree_right", x.right, tree_right);
        check_field("tree_weight", x.weight, tree_weight);
        check_field("tree_last", x.last, tree_last);
        check_field("tree_none", x.none, tree_none);
        check_field("edges_dropped", x.drop, edges_dropped);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL kruskal_min_spanning_tree");
      $finish;
    end
  end

  task automatic add_edge(input int l, input int r, input int w, input bit f);
    edge_req_t q;
    q = '{left: VERT_W'(l), right: VERT_W'(r), weight: WEIGHT_BITS'(w), fin: f};
    pending_edges.push_back(q);
  endtask

  function automatic int rand_weight();
    case ($urandom_range(5, 0))
      0: return $urandom_range(6, 0) - 3;          // heavy ties
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic int rand_vertex(input int top);
    if ($urandom_range(19, 0) == 0) return $urandom_range(127, 0);  // out of range
    return $urandom_range(top, 1);
  endfunction

  task automatic add_graph(input int n);
    int top;
    top = ($urandom_range(3, 0) == 0) ? MAX_VERTICES : $urandom_range(8, 2);
    for (int i = 1; i <= n; i++)
      add_edge(rand_vertex(top), rand_vertex(top), rand_weight(), i == n);
  endtask

  task automatic drain();
    while (pending_edges.size() > 0 || start || expected_tree.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int budget;
    int pcts[4] = '{0, 79, 0, 14};
    start = 0;
    edge_left = 0;
    edge_right = 0;
    edge_weight = 0;
    final_edge = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: lone edge, self loop, out-of-range ends, extreme weights, ties.
    add_edge(1, 64, 32'sh7fff_ffff, 1);
    add_edge(5, 5, 0, 1);
    add_edge(0, 3, 1, 0);
    add_edge(3, 127, 1, 0);
    add_edge(64, 64, 2, 1);
    add_edge(1, 2, 32'sh8000_0000, 0);
    add_edge(2, 3, 32'sh7fff_ffff, 0);
    add_edge(1, 3, 32'sh8000_0000, 0);
    add_edge(3, 4, -1, 0);
    add_edge(4, 1, 0, 1);
    add_edge(1, 2, 7, 0);
    add_edge(2, 3, 7, 0);
    add_edge(3, 1, 7, 0);
    add_edge(3, 4, 7, 0);
    add_edge(4, 5, 7, 0);
    add_edge(5, 1, 7, 1);
    add_edge(63, 64, 5, 0);
    add_edge(42, 21, -5, 1);
    drain();

    // Overflow graph: more edges than the list holds, closing edge dropped.
    for (int i = 1; i <= MAX_EDGES + 2; i++)
      add_edge(rand_vertex(MAX_VERTICES), rand_vertex(MAX_VERTICES), rand_weight(),
               i == MAX_EDGES + 2);
    drain();

    // Random graphs across idling phases.
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      budget = 50;
      while (budget > 0) begin
        int n;
        n = $urandom_range(12, 1);
        add_graph(n);
        budget -= n;
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d edges in %0d graphs; %0d tree results checked.",
             edges_sent, graphs_done, tree_seen);
    if (errors == 0) begin
      $display("PASS kruskal_min_spanning_tree");
    end else begin
      $display("FAIL kruskal_min_spanning_tree");
    end
    $finish;
  end

endmodule
